[design/gjsc_pkg.sv]
// Package: shared constants, signature strings and result type for the signature checker.
`timescale 1ns / 1ps
`default_nettype none
package gjsc_pkg;

  localparam int WindowDepth  = 22;
  localparam int PatCount     = 4;
  localparam int PatMaxLen    = WindowDepth + 1;

  localparam logic [7:0] MarkPrefix = 8'hFF;
  localparam logic [7:0] MarkSoi    = 8'hD8;

  // Strings are right-aligned: the final character sits in bits [7:0]
  localparam logic [8*PatMaxLen-1:0] PatText [PatCount] = '{
    (8*PatMaxLen)'("hdrgm:Version=\"1.0\""),
    (8*PatMaxLen)'("Item:Semantic=\"GainMap\""),
    (8*PatMaxLen)'("MPF"),
    (8*PatMaxLen)'({"ICC_", "PROFILE"})
  };

  localparam int PatLen [PatCount] = '{19, 23, 3, 11};

  localparam int PatVersion = 0;
  localparam int PatGainMap = 1;
  localparam int PatMpf     = 2;
  localparam int PatIcc     = 3;

  typedef struct packed {
    logic stream_valid;
    logic starts_with_soi;
    logic found_version_tag;
    logic found_gainmap_item;
    logic found_mpf;
    logic found_icc;
    logic two_soi_seen;
  } result_t;

endpackage
`default_nettype wire

[design/gjsc_if.sv]
// Interfaces: byte input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface gjsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gjsc_out_if;
  logic valid;
  logic ready;
  logic stream_valid;
  logic starts_with_soi;
  logic found_version_tag;
  logic found_gainmap_item;
  logic found_mpf;
  logic found_icc;
  logic two_soi_seen;

  modport source (
    output valid, output stream_valid, output starts_with_soi, output found_version_tag,
    output found_gainmap_item, output found_mpf, output found_icc, output two_soi_seen,
    input ready
  );
  modport sink (
    input valid, input stream_valid, input starts_with_soi, input found_version_tag,
    input found_gainmap_item, input found_mpf, input found_icc, input two_soi_seen,
    output ready
  );
endinterface
`default_nettype wire

[design/gjsc_cell.sv]
// Window cell: holds one past byte, passes it on, and compares it with each signature.
`timescale 1ns / 1ps
`default_nettype none
module gjsc_cell #(
  parameter int Index = 0
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           shift,
  input  wire logic                           clear,
  input  wire logic [7:0]                     din,
  output logic      [7:0]                     dout,
  output logic      [gjsc_pkg::PatCount-1:0]  match
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= 8'h00;
    end else if (shift) begin
      held <= din;
    end
  end

  assign dout = held;

  // A signature shorter than this position does not look at this cell
  always_comb begin
    for (int p = 0; p < gjsc_pkg::PatCount; p++) begin
      if (Index + 1 >= gjsc_pkg::PatLen[p]) begin
        match[p] = 1'b1;
      end else begin
        match[p] = (held == gjsc_pkg::PatText[p][8*(Index+1) +: 8]);
      end
    end
  end

endmodule
`default_nettype wire

[design/gjsc_tracker.sv]
// Stream tracker: length count, start check, signature flags and SOI pair count.
`timescale 1ns / 1ps
`default_nettype none
module gjsc_tracker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic                           last,
  input  wire logic                           pair,
  input  wire logic [gjsc_pkg::PatCount-1:0]  hit,
  output gjsc_pkg::result_t                   result
);

  logic [2:0]                    bytes_seen;
  logic                          start_ok;
  logic [gjsc_pkg::PatCount-1:0] pattern_found;
  logic [1:0]                    soi_pairs;

  logic                          start_ok_next;
  logic [gjsc_pkg::PatCount-1:0] pattern_found_next;
  logic [1:0]                    soi_pairs_next;
  logic [2:0]                    bytes_seen_next;
  logic                          soi;
  logic                          two;

  always_comb begin
    start_ok_next      = start_ok | (pair && (bytes_seen == 3'd1));
    pattern_found_next = pattern_found | hit;
    soi_pairs_next     = (pair && (soi_pairs < 2'd2)) ? soi_pairs + 2'd1 : soi_pairs;
    bytes_seen_next    = (bytes_seen < 3'd4) ? bytes_seen + 3'd1 : bytes_seen;
  end

  always_comb begin
    soi = start_ok_next && (bytes_seen >= 3'd3);
    two = (soi_pairs_next >= 2'd2);
    result.starts_with_soi    = soi;
    result.found_version_tag  = pattern_found_next[gjsc_pkg::PatVersion];
    result.found_gainmap_item = pattern_found_next[gjsc_pkg::PatGainMap];
    result.found_mpf          = pattern_found_next[gjsc_pkg::PatMpf];
    result.found_icc          = pattern_found_next[gjsc_pkg::PatIcc];
    result.two_soi_seen       = two;
    result.stream_valid       = soi && (&pattern_found_next) && two;
  end

  // Drop all stream state after the last byte
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      bytes_seen    <= 3'd0;
      start_ok      <= 1'b0;
      pattern_found <= '0;
      soi_pairs     <= 2'd0;
    end else if (accept) begin
      bytes_seen    <= bytes_seen_next;
      start_ok      <= start_ok_next;
      pattern_found <= pattern_found_next;
      soi_pairs     <= soi_pairs_next;
    end
  end

endmodule
`default_nettype wire

[design/gainmap_jpeg_signature_check_core.sv]
// Top level: gain-map JPEG signature checker built from a row of window cells.
// Takes one byte of a stream per cycle, with the final byte marked by last_byte, and
// returns one result item per stream, in the cycle after the final byte is taken:
// the overall verdict and the flags for the SOI start, the four signature strings and
// a second FF D8 pair. The 22 window cells compare their
// held byte against all signatures in parallel while the row shifts. The result
// register frees as it is taken, so input stalls only while a result waits unread.
`timescale 1ns / 1ps
`default_nettype none
module gainmap_jpeg_signature_check_core (
  input wire logic   clk,
  input wire logic   rst,
  gjsc_in_if.sink    byte_in,
  gjsc_out_if.source result_out
);

  localparam int Depth = gjsc_pkg::WindowDepth;
  localparam int Pats  = gjsc_pkg::PatCount;

  logic [7:0]      win   [Depth];
  logic [Pats-1:0] cmatch [Depth];
  logic            accept;
  logic            shift;
  logic            clear;
  logic            pair;
  logic [Pats-1:0] hit;
  logic            out_valid;
  gjsc_pkg::result_t result;
  gjsc_pkg::result_t out_data;

  assign byte_in.ready = !out_valid || result_out.ready;
  assign accept        = byte_in.valid && byte_in.ready;
  assign shift         = accept && !byte_in.last_byte;
  assign clear         = accept && byte_in.last_byte;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic [7:0] cell_in;
    if (k == 0) begin : g_head
      assign cell_in = byte_in.data_byte;
    end else begin : g_body
      assign cell_in = win[k-1];
    end
    gjsc_cell #(
      .Index(k)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(shift),
      .clear(clear),
      .din  (cell_in),
      .dout (win[k]),
      .match(cmatch[k])
    );
  end

  // A signature ends on the current byte when its last character matches
  // and every cell it covers agrees
  always_comb begin
    for (int p = 0; p < Pats; p++) begin
      hit[p] = (byte_in.data_byte == gjsc_pkg::PatText[p][7:0]);
    end
    for (int k = 0; k < Depth; k++) begin
      hit = hit & cmatch[k];
    end
  end

  assign pair = (win[0] == gjsc_pkg::MarkPrefix) && (byte_in.data_byte == gjsc_pkg::MarkSoi);

  gjsc_tracker u_tracker (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .last  (byte_in.last_byte),
    .pair  (pair),
    .hit   (hit),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (clear) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      out_data <= result;
    end
  end

  assign result_out.valid              = out_valid;
  assign result_out.stream_valid       = out_data.stream_valid;
  assign result_out.starts_with_soi    = out_data.starts_with_soi;
  assign result_out.found_version_tag  = out_data.found_version_tag;
  assign result_out.found_gainmap_item = out_data.found_gainmap_item;
  assign result_out.found_mpf          = out_data.found_mpf;
  assign result_out.found_icc          = out_data.found_icc;
  assign result_out.two_soi_seen       = out_data.two_soi_seen;

endmodule
`default_nettype wire

[verif/testbench.sv]
// Testbench: byte streams into the gain-map signature checker, verdicts checked against a predictor.
`timescale 1ns / 1ps
module testbench;

  localparam int CycleLimit    = 400000;
  localparam int HoldCycles    = 300;
  localparam int ItemsTarget   = 1900;
  localparam int StreamsTarget = 40;

  typedef enum {
    ChunkVersion, ChunkGainMap, ChunkMpf, ChunkIcc, ChunkSoi,
    ChunkNoise, ChunkBroken, ChunkMarker
  } chunk_t;

  class signature_scoreboard;
    string              signatures [gjsc_pkg::PatCount];
    logic [7:0]         history [gjsc_pkg::WindowDepth];
    int unsigned        prior_bytes;
    bit                 start_marked;
    bit [3:0]           strings_hit;
    int unsigned        soi_count;
    gjsc_pkg::result_t  pending [$];
    int unsigned        failures;

    function new();
      signatures[gjsc_pkg::PatVersion] = "hdrgm:Version=\"1.0\"";
      signatures[gjsc_pkg::PatGainMap] = "Item:Semantic=\"GainMap\"";
      signatures[gjsc_pkg::PatMpf]     = "MPF";
      signatures[gjsc_pkg::PatIcc]     = {"ICC_", "PROFILE"};
      failures = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (history[k]) history[k] = 8'h00;
      prior_bytes  = 0;
      start_marked = 1'b0;
      strings_hit  = '0;
      soi_count    = 0;
    endfunction

    // The string matches when its last char is the current byte and the rest
    // sits in the history, most recent first.
    function bit string_ends_on(string s, logic [7:0] cur);
      int n;
      n = s.len();
      if (cur != 8'(s[n-1])) return 1'b0;
      for (int k = 0; k + 1 < n; k++) begin
        if (history[k] != 8'(s[n-2-k])) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] cur, logic fin);
      bit                pair;
      gjsc_pkg::result_t want;
      pair = (history[0] == gjsc_pkg::MarkPrefix) && (cur == gjsc_pkg::MarkSoi);
      if (pair && prior_bytes == 1) start_marked = 1'b1;
      if (pair && soi_count < 2) soi_count++;
      for (int i = 0; i < gjsc_pkg::PatCount; i++) begin
        if (string_ends_on(signatures[i], cur)) strings_hit[i] = 1'b1;
      end
      if (fin) begin
        want.starts_with_soi    = start_marked && (prior_bytes >= 3);
        want.found_version_tag  = strings_hit[gjsc_pkg::PatVersion];
        want.found_gainmap_item = strings_hit[gjsc_pkg::PatGainMap];
        want.found_mpf          = strings_hit[gjsc_pkg::PatMpf];
        want.found_icc          = strings_hit[gjsc_pkg::PatIcc];
        want.two_soi_seen       = (soi_count >= 2);
        want.stream_valid       = want.starts_with_soi && (&strings_hit) && want.two_soi_seen;
        pending = {pending, want};
        clear_stream();
      end else begin
        for (int k = gjsc_pkg::WindowDepth - 1; k > 0; k--) history[k] = history[k-1];
        history[0] = cur;
        if (prior_bytes < 4) prior_bytes++;
      end
    endfunction

    function void compare_flag(string name, logic want, logic got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(gjsc_pkg::result_t got);
      gjsc_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, got);
        failures++;
        return;
      end
      want = pending.pop_front();
      compare_flag("stream_valid", want.stream_valid, got.stream_valid);
      compare_flag("starts_with_soi", want.starts_with_soi, got.starts_with_soi);
      compare_flag("found_version_tag", want.found_version_tag, got.found_version_tag);
      compare_flag("found_gainmap_item", want.found_gainmap_item, got.found_gainmap_item);
      compare_flag("found_mpf", want.found_mpf, got.found_mpf);
      compare_flag("found_icc", want.found_icc, got.found_icc);
      compare_flag("two_soi_seen", want.two_soi_seen, got.two_soi_seen);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  gjsc_in_if  byte_in ();
  gjsc_out_if result_out ();

  gainmap_jpeg_signature_check_core dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .result_out (result_out)
  );

  signature_scoreboard verdicts = new();

  logic [7:0]  stream_bytes [$];
  int          src_idle_pct = 24;
  int          sink_idle_pct = 84;
  bit          hold_request = 1'b0;
  int unsigned items_sent = 0;
  int unsigned streams_sent = 0;
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] d, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_in.valid <= 1'b0;
      @(posedge clk);
    end
    byte_in.valid     <= 1'b1;
    byte_in.data_byte <= d;
    byte_in.last_byte <= fin;
    do @(posedge clk); while (byte_in.ready !== 1'b1);
    verdicts.note_byte(d, fin);
    items_sent++;
  endtask

  task automatic send_stream();
    foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    streams_sent++;
  endtask

  // Drop valid and hold until every verdict has been taken.
  task automatic wait_drained();
    byte_in.valid <= 1'b0;
    while (verdicts.pending.size() != 0) @(posedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b);
    stream_bytes = {stream_bytes, b};
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(8'(s[i]));
  endfunction

  function automatic void make_short_stream();
    stream_bytes.delete();
    if ($urandom_range(1)) begin
      add_byte(gjsc_pkg::MarkPrefix);
      add_byte(gjsc_pkg::MarkSoi);
    end
    repeat ($urandom_range(4, stream_bytes.size() == 0 ? 1 : 0))
      add_byte(8'($urandom_range(255)));
  endfunction

  initial begin : result_drain
    int                hold_left;
    gjsc_pkg::result_t got;
    hold_left = 0;
    result_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_out.valid === 1'b1 && result_out.ready === 1'b1) begin
        got = {result_out.stream_valid, result_out.starts_with_soi,
               result_out.found_version_tag, result_out.found_gainmap_item,
               result_out.found_mpf, result_out.found_icc, result_out.two_soi_seen};
        verdicts.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("gainmap_jpeg_signature_check_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    chunk_t plan [$];
    chunk_t swap;
    string  text;
    int     pos;
    int     pick;
    byte_in.valid     = 1'b0;
    byte_in.data_byte = 8'h00;
    byte_in.last_byte = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single byte, SOI too short to count, trailing FF that must not pair
    // with the next stream, minimal valid start, late pair, string on last byte.
    stream_bytes = '{8'h00};
    send_stream();
    stream_bytes = '{8'hFF, 8'hD8};
    send_stream();
    stream_bytes = '{8'hFF, 8'hD8, 8'hFF};
    send_stream();
    stream_bytes = '{8'hD8, 8'hFF, 8'hD8, 8'h4D, 8'h50, 8'h46};
    send_stream();
    stream_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hD8};
    send_stream();
    stream_bytes = '{8'hFF, 8'hFF, 8'hD8, 8'h00};
    send_stream();

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin src_idle_pct = 24; sink_idle_pct = 84; end
        1: begin src_idle_pct = 84; sink_idle_pct = 24; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      if (phase == 2) begin
        // Receiver stops for a long stretch; back-to-back streams fill the block.
        hold_request = 1'b1;
        repeat (6) begin
          make_short_stream();
          send_stream();
        end
      end
      while (items_sent < (phase + 1) * ItemsTarget / 3 ||
             (phase == 2 && streams_sent < StreamsTarget)) begin
        if ($urandom_range(99) < 30) begin
          make_short_stream();
        end else begin
          stream_bytes.delete();
          if ($urandom_range(9) != 0) begin
            add_byte(gjsc_pkg::MarkPrefix);
            add_byte(gjsc_pkg::MarkSoi);
          end else begin
            add_byte(8'($urandom_range(255)));
            add_byte(8'($urandom_range(255)));
          end
          plan.delete();
          for (int c = ChunkVersion; c <= ChunkSoi; c++) begin
            if ($urandom_range(99) < 85) plan = {plan, chunk_t'(c)};
          end
          repeat ($urandom_range(5, 2))
            plan = {plan, chunk_t'($urandom_range(ChunkMarker, ChunkNoise))};
          for (int j = plan.size() - 1; j > 0; j--) begin
            pick = $urandom_range(j);
            swap = plan[j];
            plan[j] = plan[pick];
            plan[pick] = swap;
          end
          foreach (plan[j]) begin
            case (plan[j])
              ChunkVersion: add_text(verdicts.signatures[gjsc_pkg::PatVersion]);
              ChunkGainMap: add_text(verdicts.signatures[gjsc_pkg::PatGainMap]);
              ChunkMpf:     add_text(verdicts.signatures[gjsc_pkg::PatMpf]);
              ChunkIcc:     add_text(verdicts.signatures[gjsc_pkg::PatIcc]);
              ChunkSoi: begin
                add_byte(gjsc_pkg::MarkPrefix);
                add_byte(gjsc_pkg::MarkSoi);
              end
              ChunkNoise: repeat ($urandom_range(4)) add_byte(8'($urandom_range(255)));
              ChunkMarker: begin
                case ($urandom_range(2))
                  0: add_byte(gjsc_pkg::MarkPrefix);
                  1: add_byte(gjsc_pkg::MarkSoi);
                  default: begin
                    add_byte(gjsc_pkg::MarkPrefix);
                    add_byte(gjsc_pkg::MarkPrefix);
                    add_byte(gjsc_pkg::MarkSoi);
                  end
                endcase
              end
              default: begin
                // Near miss: one char replaced, dropped, or the string cut short.
                text = verdicts.signatures[$urandom_range(gjsc_pkg::PatCount - 1)];
                pos = $urandom_range(text.len() - 1);
                case ($urandom_range(2))
                  0: text.putc(pos, byte'($urandom_range(255)));
                  1: text = {text.substr(0, pos - 1), text.substr(pos + 1, text.len() - 1)};
                  default: text = text.substr(0, pos);
                endcase
                add_text(text);
              end
            endcase
          end
        end
        send_stream();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (verdicts.failures == 0 && verdicts.pending.size() == 0) begin
      $display("gainmap_jpeg_signature_check_core regression: pass");
    end else begin
      $display("gainmap_jpeg_signature_check_core regression: fail");
    end
    $finish;
  end

endmodule
